### rtl/core/prs_pkg.sv
// Package for the persistent range-sum tree unit: sizes, codes, request and
// result types, node and stack frame layouts, controller states.
// Depends on nothing; persistent_range_sum_tree_unit imports it.
package prs_pkg;

	localparam int MAX_LEAVES   = 1024;
	localparam int MAX_VERSIONS = 1024;
	localparam int POOL_NODES   = 16384;

	localparam int POS_W   = 11;
	localparam int SUM_W   = 64;
	localparam int VER_W   = 11;
	localparam int NODE_AW = $clog2(POOL_NODES);
	localparam int IV_AW   = $clog2(MAX_LEAVES);
	localparam int VR_AW   = $clog2(MAX_VERSIONS);
	localparam int USED_W  = $clog2(POOL_NODES + 1);
	localparam int BSTK_D  = IV_AW + 1;
	localparam int BIDX_W  = $clog2(BSTK_D);
	localparam int BSP_W   = $clog2(BSTK_D + 1);
	localparam int QSTK_D  = 24;
	localparam int QIDX_W  = $clog2(QSTK_D);
	localparam int QSP_W   = $clog2(QSTK_D + 1);
	localparam int CNT_W   = $clog2(IV_AW + 3);

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_BUILD = 2'd1,
		OP_ADD   = 2'd2,
		OP_QUERY = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_POS   = 3'd1,
		ST_BAD_VER   = 3'd2,
		ST_FULL      = 3'd3,
		ST_NOT_BUILT = 3'd4
	} status_t;

	typedef struct packed {
		opcode_t            opcode;
		logic [POS_W-1:0]   position;
		logic [POS_W-1:0]   range_end;
		logic signed [63:0] amount;
		logic [VER_W-1:0]   version;
	} prs_req_t;

	typedef struct packed {
		logic signed [63:0] range_sum;
		logic [VER_W-1:0]   new_version;
		status_t            status;
	} prs_res_t;

	typedef struct packed {
		logic [SUM_W-1:0]   sum;
		logic [NODE_AW-1:0] lchild;
		logic [NODE_AW-1:0] rchild;
	} node_t;

	typedef struct packed {
		logic [POS_W-1:0]   lo_b;
		logic [POS_W-1:0]   hi_e;
		logic               right_phase;
		logic [NODE_AW-1:0] lidx;
		logic [SUM_W-1:0]   lsum;
	} bframe_t;

	typedef struct packed {
		logic [NODE_AW-1:0] idx;
		logic [POS_W-1:0]   lo_b;
		logic [POS_W-1:0]   hi_e;
	} qframe_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_B_CALL,
		S_B_LEAF,
		S_B_RET,
		S_A_COUNT,
		S_A_ROOT,
		S_A_ROOTW,
		S_A_RD,
		S_A_WR,
		S_A_END,
		S_Q_ROOT,
		S_Q_INIT,
		S_Q_POP,
		S_Q_NODE,
		S_FIN
	} prs_state_t;

endpackage

### rtl/core/prs_ram.sv
// Generic simple dual-port RAM: one write port, one read port, read data
// registered. No dependencies.
module prs_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/persistent_range_sum_tree_unit.sv
// Top level of the persistent range-sum tree unit: controller, walk stacks,
// config register and the three RAMs (initial values, node pool, version roots).
// Depends on prs_pkg and prs_ram.
//
// One request at a time: a request is taken when start is high and busy is
// low, and its result appears for one cycle with done, which cannot be held
// off. After reset every entry of the initial-value memory is cleared with
// busy high. Load and any request rejected at once go straight to the result
// state; an add refused for lack of pool nodes is refused once the path is
// sized. Build walks the tree depth first, writing each leaf and then each
// inner node once both its subtrees are done, with at most one node write per
// cycle. Add sizes the path, fetches the root from the version-root memory,
// then reads and rewrites each path node in turn (node pool reads are registered).
// Query fetches the root, then takes node frames off a walk stack; a node outside
// the range is dropped unread; up to about 4*log2(leaves) nodes are examined.
module persistent_range_sum_tree_unit (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  prs_pkg::prs_req_t        cmd,
	output logic                     done,
	output prs_pkg::prs_res_t        result,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [2:0]               paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready
);
	import prs_pkg::*;

	prs_state_t state_q, state_d;

	logic [POS_W-1:0]   leaf_count_q;
	logic [POS_W-1:0]   n_q;
	logic [USED_W-1:0]  nodes_used_q;
	logic [VER_W-1:0]   versions_q;
	prs_req_t           req_q;
	logic [POS_W-1:0]   cb_q, ce_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [NODE_AW-1:0] cur_q, root_q, ret_idx_q;
	logic [SUM_W-1:0]   ret_sum_q, acc_q;
	logic               cont_q;
	bframe_t            bstk_q [BSTK_D];
	logic [BSP_W-1:0]   bsp_q;
	qframe_t            qstk_q [QSTK_D];
	logic [QSP_W-1:0]   qsp_q;
	logic [IV_AW-1:0]   clr_q;
	logic [SUM_W-1:0]   res_sum_q;
	logic [VER_W-1:0]   res_ver_q;
	status_t            res_st_q;

	// memory ports
	logic               iv_we, nd_we, vr_we;
	logic [IV_AW-1:0]   iv_waddr, iv_raddr;
	logic [SUM_W-1:0]   iv_wdata, iv_rdata;
	logic [NODE_AW-1:0] nd_waddr, nd_raddr;
	node_t              nd_wdata, nd_rdata;
	logic [VR_AW-1:0]   vr_waddr, vr_raddr;
	logic [NODE_AW-1:0] vr_wdata, vr_rdata;

	logic               accept, built, cfg_wr;
	logic [POS_W-1:0]   eff_n, mid;
	status_t            acc_st;
	logic [NODE_AW-1:0] alloc;
	bframe_t            btop;
	qframe_t            qtop;
	logic [POS_W-1:0]   btop_mid;
	logic               q_disjoint, q_contained;
	logic [USED_W-1:0]  room;

	function automatic logic [POS_W-1:0] mid_of(input logic [POS_W-1:0] b,
		input logic [POS_W-1:0] e);
		logic [POS_W:0] s;
		s = {1'b0, b} + {1'b0, e};
		return s[POS_W:1];
	endfunction

	assign accept = start && !busy;
	assign built  = versions_q != '0;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {{(32 - POS_W){1'b0}}, leaf_count_q} : 32'd0;

	always_comb begin
		if (leaf_count_q == '0) begin
			eff_n = POS_W'(1);
		end else if (32'(leaf_count_q) > MAX_LEAVES) begin
			eff_n = POS_W'(MAX_LEAVES);
		end else begin
			eff_n = leaf_count_q;
		end
	end

	assign mid      = mid_of(cb_q, ce_q);
	assign alloc    = nodes_used_q[NODE_AW-1:0];
	assign btop     = bstk_q[BIDX_W'(bsp_q - BSP_W'(1))];
	assign btop_mid = mid_of(btop.lo_b, btop.hi_e);
	assign qtop     = qstk_q[QIDX_W'(qsp_q - QSP_W'(1))];
	assign q_disjoint  = (qtop.lo_b > req_q.range_end) || (qtop.hi_e < req_q.position);
	assign q_contained = (qtop.lo_b >= req_q.position) && (qtop.hi_e <= req_q.range_end);
	assign room     = USED_W'(POOL_NODES) - nodes_used_q;

	// status decided when the request is taken (an add's pool-room check comes later)
	always_comb begin
		acc_st = ST_OK;
		unique case (cmd.opcode)
			OP_LOAD: begin
				if (cmd.position == '0 || cmd.position > eff_n) acc_st = ST_BAD_POS;
			end
			OP_BUILD: begin
				if (32'(eff_n) * 2 - 1 > POOL_NODES) acc_st = ST_FULL;
			end
			OP_ADD: begin
				priority if (!built) acc_st = ST_NOT_BUILT;
				else if (cmd.position == '0 || cmd.position > n_q) acc_st = ST_BAD_POS;
				else if (32'(versions_q) >= MAX_VERSIONS) acc_st = ST_FULL;
				else acc_st = ST_OK;
			end
			OP_QUERY: begin
				priority if (!built) acc_st = ST_NOT_BUILT;
				else if (cmd.version == '0 || cmd.version > versions_q) acc_st = ST_BAD_VER;
				else if (cmd.position == '0 || cmd.position > cmd.range_end ||
					cmd.range_end > n_q) acc_st = ST_BAD_POS;
				else acc_st = ST_OK;
			end
			default: acc_st = ST_OK;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: if (32'(clr_q) == MAX_LEAVES - 1) state_d = S_IDLE;
			S_IDLE: begin
				if (accept) begin
					if (acc_st != ST_OK) begin
						state_d = S_FIN;
					end else begin
						unique case (cmd.opcode)
							OP_LOAD:  state_d = S_FIN;
							OP_BUILD: state_d = S_B_CALL;
							OP_ADD:   state_d = S_A_COUNT;
							OP_QUERY: state_d = S_Q_ROOT;
							default:  state_d = S_FIN;
						endcase
					end
				end
			end
			S_B_CALL:  state_d = (cb_q == ce_q) ? S_B_LEAF : S_B_CALL;
			S_B_LEAF:  state_d = S_B_RET;
			S_B_RET: begin
				if (bsp_q == '0) state_d = S_FIN;
				else if (!btop.right_phase) state_d = S_B_CALL;
			end
			S_A_COUNT: begin
				if (cb_q == ce_q) begin
					state_d = (USED_W'(cnt_q) > room) ? S_FIN : S_A_ROOT;
				end
			end
			S_A_ROOT:  state_d = S_A_ROOTW;
			S_A_ROOTW: state_d = S_A_RD;
			S_A_RD:    state_d = S_A_WR;
			S_A_WR:    state_d = (cb_q == ce_q) ? S_A_END : S_A_RD;
			S_A_END:   state_d = S_FIN;
			S_Q_ROOT:  state_d = S_Q_INIT;
			S_Q_INIT:  state_d = S_Q_POP;
			S_Q_POP: begin
				if (qsp_q == '0) state_d = S_FIN;
				else if (!q_disjoint) state_d = S_Q_NODE;
			end
			S_Q_NODE:  state_d = S_Q_POP;
			S_FIN:     state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// memory controls and handshake outputs
	always_comb begin
		iv_we    = 1'b0;
		iv_waddr = '0;
		iv_wdata = '0;
		iv_raddr = IV_AW'(cb_q - POS_W'(1));
		nd_we    = 1'b0;
		nd_waddr = alloc;
		nd_wdata = '0;
		nd_raddr = cur_q;
		vr_we    = 1'b0;
		vr_waddr = '0;
		vr_wdata = ret_idx_q;
		vr_raddr = VR_AW'(versions_q - VER_W'(1));
		busy     = state_q != S_IDLE;
		done     = state_q == S_FIN;
		unique case (state_q)
			S_CLEAR: begin
				iv_we    = 1'b1;
				iv_waddr = clr_q;
			end
			S_IDLE: begin
				if (accept && cmd.opcode == OP_LOAD && acc_st == ST_OK) begin
					iv_we    = 1'b1;
					iv_waddr = IV_AW'(cmd.position - POS_W'(1));
					iv_wdata = cmd.amount;
				end
			end
			S_B_LEAF: begin
				nd_we    = 1'b1;
				nd_wdata = '{sum: iv_rdata, lchild: '0, rchild: '0};
			end
			S_B_RET: begin
				if (bsp_q == '0) begin
					vr_we = 1'b1;
				end else if (btop.right_phase) begin
					nd_we    = 1'b1;
					nd_wdata = '{sum: btop.lsum + ret_sum_q, lchild: btop.lidx,
						rchild: ret_idx_q};
				end
			end
			S_A_WR: begin
				nd_we        = 1'b1;
				nd_wdata.sum = nd_rdata.sum + SUM_W'(req_q.amount);
				if (cb_q == ce_q) begin
					nd_wdata.lchild = '0;
					nd_wdata.rchild = '0;
				end else if (req_q.position <= mid) begin
					nd_wdata.lchild = alloc + NODE_AW'(1);
					nd_wdata.rchild = nd_rdata.rchild;
				end else begin
					nd_wdata.lchild = nd_rdata.lchild;
					nd_wdata.rchild = alloc + NODE_AW'(1);
				end
			end
			S_A_END: begin
				vr_we    = 1'b1;
				vr_waddr = versions_q[VR_AW-1:0];
				vr_wdata = root_q;
			end
			S_Q_ROOT: vr_raddr = VR_AW'(req_q.version - VER_W'(1));
			S_Q_POP:  nd_raddr = qtop.idx;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			leaf_count_q <= POS_W'(MAX_LEAVES);
			n_q          <= '0;
			nodes_used_q <= '0;
			versions_q   <= '0;
			bsp_q        <= '0;
			qsp_q        <= '0;
			clr_q        <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_wr && paddr[2] == 1'b0) leaf_count_q <= pwdata[POS_W-1:0];
			unique case (state_q)
				S_CLEAR: clr_q <= clr_q + IV_AW'(1);
				S_IDLE: begin
					if (accept) begin
						req_q     <= cmd;
						res_st_q  <= acc_st;
						res_sum_q <= '0;
						res_ver_q <= '0;
						cnt_q     <= CNT_W'(1);
						root_q    <= alloc;
						qsp_q     <= '0;
						if (cmd.opcode == OP_BUILD) begin
							cb_q <= POS_W'(1);
							ce_q <= eff_n;
							if (acc_st == ST_OK) begin
								nodes_used_q <= '0;
								n_q          <= eff_n;
								bsp_q        <= '0;
							end
						end else begin
							cb_q <= POS_W'(1);
							ce_q <= n_q;
						end
					end
				end
				S_B_CALL: begin
					if (cb_q != ce_q) begin
						bstk_q[BIDX_W'(bsp_q)] <= '{lo_b: cb_q, hi_e: ce_q, right_phase: 1'b0,
							lidx: '0, lsum: '0};
						bsp_q <= bsp_q + BSP_W'(1);
						ce_q  <= mid;
					end
				end
				S_B_LEAF: begin
					ret_idx_q    <= alloc;
					ret_sum_q    <= iv_rdata;
					nodes_used_q <= nodes_used_q + USED_W'(1);
				end
				S_B_RET: begin
					if (bsp_q == '0) begin
						versions_q <= VER_W'(1);
						res_ver_q  <= VER_W'(1);
					end else if (!btop.right_phase) begin
						// left subtree finished: remember it, descend right
						bstk_q[BIDX_W'(bsp_q - BSP_W'(1))].right_phase <= 1'b1;
						bstk_q[BIDX_W'(bsp_q - BSP_W'(1))].lidx <= ret_idx_q;
						bstk_q[BIDX_W'(bsp_q - BSP_W'(1))].lsum <= ret_sum_q;
						cb_q <= btop_mid + POS_W'(1);
						ce_q <= btop.hi_e;
					end else begin
						ret_idx_q    <= alloc;
						ret_sum_q    <= btop.lsum + ret_sum_q;
						nodes_used_q <= nodes_used_q + USED_W'(1);
						bsp_q        <= bsp_q - BSP_W'(1);
					end
				end
				S_A_COUNT: begin
					if (cb_q != ce_q) begin
						if (req_q.position <= mid) ce_q <= mid;
						else cb_q <= mid + POS_W'(1);
						cnt_q <= cnt_q + CNT_W'(1);
					end else begin
						cb_q <= POS_W'(1);
						ce_q <= n_q;
						if (USED_W'(cnt_q) > room) res_st_q <= ST_FULL;
					end
				end
				S_A_ROOTW: cur_q <= vr_rdata;
				S_A_WR: begin
					nodes_used_q <= nodes_used_q + USED_W'(1);
					if (req_q.position <= mid) begin
						cur_q <= nd_rdata.lchild;
						ce_q  <= mid;
					end else begin
						cur_q <= nd_rdata.rchild;
						cb_q  <= mid + POS_W'(1);
					end
				end
				S_A_END: begin
					versions_q <= versions_q + VER_W'(1);
					res_ver_q  <= versions_q + VER_W'(1);
				end
				S_Q_INIT: begin
					qstk_q[0] <= '{idx: vr_rdata, lo_b: POS_W'(1), hi_e: n_q};
					qsp_q     <= QSP_W'(1);
					acc_q     <= '0;
				end
				S_Q_POP: begin
					if (qsp_q == '0) begin
						res_sum_q <= acc_q;
					end else begin
						qsp_q  <= qsp_q - QSP_W'(1);
						cb_q   <= qtop.lo_b;
						ce_q   <= qtop.hi_e;
						cont_q <= q_contained;
					end
				end
				S_Q_NODE: begin
					if (cont_q) begin
						acc_q <= acc_q + nd_rdata.sum;
					end else begin
						// split: push both halves
						qstk_q[QIDX_W'(qsp_q)] <= '{idx: nd_rdata.lchild, lo_b: cb_q,
							hi_e: mid};
						qstk_q[QIDX_W'(qsp_q + QSP_W'(1))] <= '{idx: nd_rdata.rchild,
							lo_b: mid + POS_W'(1), hi_e: ce_q};
						qsp_q <= qsp_q + QSP_W'(2);
					end
				end
				default: ;
			endcase
		end
	end

	assign result = '{range_sum: res_sum_q, new_version: res_ver_q, status: res_st_q};

	prs_ram #(.W(SUM_W), .D(MAX_LEAVES)) u_iv_ram (
		.clk(clk), .we(iv_we), .waddr(iv_waddr), .wdata(iv_wdata),
		.raddr(iv_raddr), .rdata(iv_rdata)
	);

	prs_ram #(.W($bits(node_t)), .D(POOL_NODES)) u_node_ram (
		.clk(clk), .we(nd_we), .waddr(nd_waddr), .wdata(nd_wdata),
		.raddr(nd_raddr), .rdata(nd_rdata)
	);

	prs_ram #(.W(NODE_AW), .D(MAX_VERSIONS)) u_root_ram (
		.clk(clk), .we(vr_we), .waddr(vr_waddr), .wdata(vr_wdata),
		.raddr(vr_raddr), .rdata(vr_rdata)
	);

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy || start))
		else $error("result strobe without a request in flight");

	a_qstack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(qsp_q) <= QSTK_D)
		else $error("query walk stack overflow");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != ST_OK) |-> (result.range_sum == '0 &&
		result.new_version == '0))
		else $error("rejected request returned data");

	a_pool_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(nodes_used_q) <= POOL_NODES)
		else $error("node pool overrun");

endmodule
